FILE: rtl/bpec_pkg.sv
// Shared types, codes and reset values for the button press event classifier.
package bpec_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int ADC_BITS_DEF  = 12;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;

  typedef enum logic [1:0] {
    OP_EDGE_A = 2'd0,
    OP_EDGE_B = 2'd1,
    OP_POLL   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_A_LONG  = 3'd1,
    EV_A_SHORT = 3'd2,
    EV_B       = 3'd3,
    EV_UP      = 3'd4,
    EV_DOWN    = 3'd5
  } ev_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_CENTER     = 2'd2,
    REG_DEAD_ZONE  = 2'd3
  } reg_idx_t;

  localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [11:0] CENTER_RST     = 12'd2048;
  localparam logic [10:0] DEAD_ZONE_RST  = 11'd400;

  typedef struct packed {
    logic [15:0] debounce;
    logic [15:0] long_press;
    logic [11:0] center;
    logic [10:0] dead_zone;
  } cfg_t;

  // Decision for one item: state updates and the result, if any.
  typedef struct packed {
    logic set_a;
    logic set_b;
    logic clr_a;
    logic clr_b;
    logic emit;
    ev_t  ev;
  } ctl_t;

endpackage

FILE: rtl/bpec_core.sv
// Combinational decision logic: debounce test on edges, event priority on polls.
module bpec_core
  import bpec_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int ADC_BITS  = ADC_BITS_DEF
) (
  input  logic [1:0]           op,
  input  logic [TIME_BITS-1:0] now_ms,
  input  logic                 level_a,
  input  logic [ADC_BITS-1:0]  stick_y,
  input  logic                 on_settings_screen,
  input  logic [TIME_BITS-1:0] last_a,
  input  logic [TIME_BITS-1:0] last_b,
  input  logic                 pending_a,
  input  logic                 pending_b,
  input  cfg_t                 cfg,
  output ctl_t                 ctl
);

  // compare width wide enough for center + dead zone and for the sample
  localparam int SW = (ADC_BITS > 13) ? ADC_BITS : 13;

  logic [TIME_BITS-1:0] el_a;
  logic [TIME_BITS-1:0] el_b;
  logic [TIME_BITS-1:0] deb_x;
  logic [TIME_BITS-1:0] lp_x;
  logic [SW-1:0]        y_x;
  logic [SW-1:0]        hi_lim;
  logic [SW-1:0]        lo_lim;
  logic                 up_hit;
  logic                 dn_hit;

  assign el_a   = now_ms - last_a;
  assign el_b   = now_ms - last_b;
  assign deb_x  = TIME_BITS'(cfg.debounce);
  assign lp_x   = TIME_BITS'(cfg.long_press);
  assign y_x    = SW'(stick_y);
  assign hi_lim = SW'(cfg.center) + SW'(cfg.dead_zone);
  assign lo_lim = SW'(cfg.center) - SW'(cfg.dead_zone);
  assign up_hit = y_x > hi_lim;
  // down band only exists when center sits at or above the dead zone
  assign dn_hit = (12'(cfg.dead_zone) <= cfg.center) && (y_x < lo_lim);

  always_comb begin
    ctl = '{set_a: 1'b0, set_b: 1'b0, clr_a: 1'b0, clr_b: 1'b0,
            emit: 1'b0, ev: EV_NONE};
    case (op_t'(op))
      OP_EDGE_A: begin
        ctl.set_a = el_a > deb_x;
      end
      OP_EDGE_B: begin
        ctl.set_b = el_b > deb_x;
      end
      OP_POLL: begin
        ctl.emit = 1'b1;
        if (pending_a && !level_a && (el_a >= lp_x)) begin
          ctl.clr_a = 1'b1;
          ctl.ev    = EV_A_LONG;
        end else if (pending_a && level_a) begin
          ctl.clr_a = 1'b1;
          ctl.ev    = EV_A_SHORT;
        end else if (pending_b) begin
          ctl.clr_b = 1'b1;
          ctl.ev    = EV_B;
        end else if (on_settings_screen && up_hit) begin
          ctl.ev = EV_UP;
        end else if (on_settings_screen && dn_hit) begin
          ctl.ev = EV_DOWN;
        end
      end
      default: begin
        // reserved op: dropped without effect
      end
    endcase
  end

endmodule

FILE: rtl/button_press_event_classifier_top.sv
// Top level: request register, debounce/event state, result register, config.
// A poll result is decided between the request register and the result register
// and then appears on out_*. Throughput: one request per cycle, set by the state
// update loop; stalls only when a poll finds the result register full and
// out_tready low. Reset (rst_n low, synchronous) clears pending flags and edge
// times to 0 and loads config reset values.
module button_press_event_classifier_top
  import bpec_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int ADC_BITS  = ADC_BITS_DEF,
  localparam int IN_FW    = TIME_BITS + ADC_BITS + 2,
  localparam int IN_DW    = ((IN_FW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_tvalid,
  output logic              in_tready,
  // fields from bit 0: now_ms, level_a, stick_y, on_settings_screen, zero pad
  input  logic [IN_DW-1:0]  in_tdata,
  // fields from bit 0: op
  input  logic [1:0]        in_tuser,
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  // fields from bit 0: ui_event, zero pad
  output logic [7:0]        out_tdata,
  // config write port
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  // request register
  logic                 in_v_r;
  logic [1:0]           op_r;
  logic [TIME_BITS-1:0] now_r;
  logic                 lvl_r;
  logic [ADC_BITS-1:0]  y_r;
  logic                 scr_r;

  // classifier state
  logic                 pend_a_r, pend_a_nxt;
  logic                 pend_b_r, pend_b_nxt;
  logic [TIME_BITS-1:0] last_a_r, last_a_nxt;
  logic [TIME_BITS-1:0] last_b_r, last_b_nxt;

  // result register
  logic                 out_v_r;
  ev_t                  ev_r;

  cfg_t                 cfg_r;
  ctl_t                 ctl;
  logic                 proc;
  logic                 in_acc;

  // A poll needs room in the result register; edges never block.
  assign proc      = in_v_r && ((op_t'(op_r) != OP_POLL) || !out_v_r || out_tready);
  assign in_tready = !in_v_r || proc;
  assign in_acc    = in_tvalid && in_tready;

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, ev_r};

  bpec_core #(
    .TIME_BITS(TIME_BITS),
    .ADC_BITS (ADC_BITS)
  ) u_core (
    .op                (op_r),
    .now_ms            (now_r),
    .level_a           (lvl_r),
    .stick_y           (y_r),
    .on_settings_screen(scr_r),
    .last_a            (last_a_r),
    .last_b            (last_b_r),
    .pending_a         (pend_a_r),
    .pending_b         (pend_b_r),
    .cfg               (cfg_r),
    .ctl               (ctl)
  );

  // next state; set and clear never occur for the same item
  always_comb begin
    pend_a_nxt = pend_a_r;
    pend_b_nxt = pend_b_r;
    last_a_nxt = last_a_r;
    last_b_nxt = last_b_r;
    if (proc) begin
      if (ctl.set_a) begin
        pend_a_nxt = 1'b1;
        last_a_nxt = now_r;
      end
      if (ctl.set_b) begin
        pend_b_nxt = 1'b1;
        last_b_nxt = now_r;
      end
      if (ctl.clr_a) begin
        pend_a_nxt = 1'b0;
      end
      if (ctl.clr_b) begin
        pend_b_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_a_r <= 1'b0;
      pend_b_r <= 1'b0;
      last_a_r <= '0;
      last_b_r <= '0;
    end else begin
      pend_a_r <= pend_a_nxt;
      pend_b_r <= pend_b_nxt;
      last_a_r <= last_a_nxt;
      last_b_r <= last_b_nxt;
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_tuser;
      now_r <= in_tdata[TIME_BITS-1:0];
      lvl_r <= in_tdata[TIME_BITS];
      y_r   <= in_tdata[TIME_BITS+ADC_BITS:TIME_BITS+1];
      scr_r <= in_tdata[TIME_BITS+ADC_BITS+1];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc && ctl.emit) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && ctl.emit) begin
      ev_r <= ctl.ev;
    end
  end

  // config registers; the user must write them only while idle, the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce   <= DEBOUNCE_RST;
      cfg_r.long_press <= LONG_PRESS_RST;
      cfg_r.center     <= CENTER_RST;
      cfg_r.dead_zone  <= DEAD_ZONE_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_DEBOUNCE:   cfg_r.debounce   <= cfg_wdata;
        REG_LONG_PRESS: cfg_r.long_press <= cfg_wdata;
        REG_CENTER:     cfg_r.center     <= cfg_wdata[11:0];
        REG_DEAD_ZONE:  cfg_r.dead_zone  <= cfg_wdata[10:0];
        default: begin
        end
      endcase
    end
  end

endmodule
